// File: hw/rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// Serial frame receiver package
// Shared constants, item types and the CRC-8 byte step for the receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

  // Longest frame position; lengths above this are rejected.
  localparam int MaxFrame = 64;
  localparam logic [6:0] MaxFrameW = 7'(MaxFrame);

  // CRC-8 generator polynomial, MSB first.
  localparam logic [7:0] CrcPoly = 8'hD5;

  // Reset values of the two sync byte registers.
  localparam logic [7:0] SyncPrimaryReset   = 8'd238;
  localparam logic [7:0] SyncSecondaryReset = 8'd200;

  // Configuration register indexes.
  localparam logic CfgSyncPrimary   = 1'b0;
  localparam logic CfgSyncSecondary = 1'b1;

  // Frame status codes.
  typedef enum logic [1:0] {
    STATUS_GOOD     = 2'd0,
    STATUS_CRC_BAD  = 2'd1,
    STATUS_LEN_BAD  = 2'd2,
    STATUS_OVERFLOW = 2'd3
  } frame_status_t;

  // One input item.
  typedef struct packed {
    logic       clear_counts;
    logic [7:0] rx_byte;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic          byte_in_frame;
    logic [7:0]    data_byte;
    logic [6:0]    byte_index;
    logic          frame_end;
    frame_status_t frame_status;
    logic [6:0]    frame_length;
    logic [15:0]   good_frames;
    logic [15:0]   bad_frames;
  } result_t;

  // One byte of CRC-8: eight shift steps on the combined value.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/sfr_in_stage.sv
// ----------------------------------------------------------------------------
// Serial frame receiver input stage
// Registers one input item and hands it on when the next stage advances.
// ----------------------------------------------------------------------------
module sfr_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sfr_pkg::in_item_t in_item,
  input  logic              advance,
  output logic              held_valid,
  output sfr_pkg::in_item_t held_item
);
  import sfr_pkg::*;

  // The register may load when empty or when its item moves on this cycle.
  assign in_ready = !held_valid || advance;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_item <= in_item;
    end
  end

endmodule

// File: hw/rtl/sfr_core.sv
// ----------------------------------------------------------------------------
// Serial frame receiver core
// Sync hunt, length check, CRC-8 and frame counters for one byte per cycle while advance is high.
// ----------------------------------------------------------------------------
module sfr_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              advance,
  input  sfr_pkg::in_item_t item,
  output sfr_pkg::result_t  result
);
  import sfr_pkg::*;

  logic        sync_primary;
  logic        sync_secondary;
  logic [7:0]  sync_primary_q;
  logic [7:0]  sync_secondary_q;
  logic        frame_active;
  logic        frame_active_next;
  logic [6:0]  write_position;
  logic [6:0]  write_position_next;
  logic [6:0]  expected_length;
  logic [6:0]  expected_length_next;
  logic [7:0]  running_crc;
  logic [7:0]  running_crc_next;
  logic [15:0] good_counter;
  logic [15:0] good_counter_next;
  logic [15:0] bad_counter;
  logic [15:0] bad_counter_next;
  logic [15:0] good_shown;
  logic [15:0] bad_shown;
  logic        hunt;
  logic        is_sync;
  logic        is_last;
  logic [7:0]  b;

  assign b = item.rx_byte;
  assign sync_primary   = (b == sync_primary_q);
  assign sync_secondary = (b == sync_secondary_q);
  assign is_sync = sync_primary || sync_secondary;
  assign is_last = {1'b0, write_position} >= ({1'b0, expected_length} + 8'd1);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_primary_q   <= SyncPrimaryReset;
      sync_secondary_q <= SyncSecondaryReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgSyncPrimary:   sync_primary_q   <= cfg_data;
        CfgSyncSecondary: sync_secondary_q <= cfg_data;
        default:          sync_primary_q   <= sync_primary_q;
      endcase
    end
  end

  // Frame logic for the byte in the input register.
  always_comb begin
    frame_active_next    = frame_active;
    write_position_next  = write_position;
    expected_length_next = expected_length;
    running_crc_next     = running_crc;
    good_shown           = good_counter;
    bad_shown            = bad_counter;
    hunt                 = 1'b0;
    result               = '0;
    result.data_byte     = b;
    result.frame_status  = STATUS_GOOD;

    if (!frame_active) begin
      hunt = 1'b1;
    end else if (write_position >= MaxFrameW) begin
      // Overflow: abandon the frame and look at this byte as a sync.
      result.frame_end     = 1'b1;
      result.frame_status  = STATUS_OVERFLOW;
      result.frame_length  = expected_length;
      frame_active_next    = 1'b0;
      write_position_next  = '0;
      expected_length_next = '0;
      running_crc_next     = '0;
      hunt                 = 1'b1;
    end else if (write_position == 7'd1) begin
      // Length byte.
      if (b != 8'd0 && b <= 8'(MaxFrame)) begin
        expected_length_next = b[6:0];
        result.byte_in_frame = 1'b1;
        result.byte_index    = 7'd1;
        result.frame_length  = b[6:0];
        write_position_next  = 7'd2;
      end else begin
        result.frame_end     = 1'b1;
        result.frame_status  = STATUS_LEN_BAD;
        frame_active_next    = 1'b0;
        write_position_next  = '0;
        expected_length_next = '0;
        running_crc_next     = '0;
      end
    end else begin
      // Frame body or CRC byte.
      result.byte_in_frame = 1'b1;
      result.byte_index    = write_position;
      result.frame_length  = expected_length;
      if (is_last) begin
        result.frame_end = 1'b1;
        if (running_crc == b) begin
          result.frame_status = STATUS_GOOD;
          if (good_counter != 16'hFFFF) begin
            good_shown = good_counter + 16'd1;
          end
        end else begin
          result.frame_status = STATUS_CRC_BAD;
          if (bad_counter != 16'hFFFF) begin
            bad_shown = bad_counter + 16'd1;
          end
        end
        frame_active_next    = 1'b0;
        write_position_next  = '0;
        expected_length_next = '0;
        running_crc_next     = '0;
      end else begin
        running_crc_next    = crc8_step(running_crc, b);
        write_position_next = write_position + 7'd1;
      end
    end

    // A sync byte while hunting opens a new frame.
    if (hunt && is_sync) begin
      frame_active_next    = 1'b1;
      write_position_next  = 7'd1;
      expected_length_next = '0;
      running_crc_next     = '0;
      result.byte_in_frame = 1'b1;
      result.byte_index    = '0;
      if (!result.frame_end) begin
        result.frame_length = '0;
      end
    end

    result.good_frames = good_shown;
    result.bad_frames  = bad_shown;

    // Counters clear after this byte's result has been formed.
    good_counter_next = item.clear_counts ? 16'd0 : good_shown;
    bad_counter_next  = item.clear_counts ? 16'd0 : bad_shown;
  end

  // Frame state.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_active    <= 1'b0;
      write_position  <= '0;
      expected_length <= '0;
      running_crc     <= '0;
      good_counter    <= '0;
      bad_counter     <= '0;
    end else if (advance) begin
      frame_active    <= frame_active_next;
      write_position  <= write_position_next;
      expected_length <= expected_length_next;
      running_crc     <= running_crc_next;
      good_counter    <= good_counter_next;
      bad_counter     <= bad_counter_next;
    end
  end

endmodule

// File: hw/rtl/sfr_out_stage.sv
// ----------------------------------------------------------------------------
// Serial frame receiver output stage
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module sfr_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load_valid,
  output logic             can_load,
  input  sfr_pkg::result_t load_item,
  output logic             out_valid,
  input  logic             out_ready,
  output sfr_pkg::result_t out_item
);
  import sfr_pkg::*;

  // Free when empty or when the held item leaves this cycle.
  assign can_load = !out_valid || out_ready;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load_valid;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (can_load && load_valid) begin
      out_item <= load_item;
    end
  end

endmodule

// File: hw/rtl/serial_frame_receiver_crc8_unit.sv
// ----------------------------------------------------------------------------
// Serial frame receiver with CRC-8
// An accepted item is held in the input register, and its result in the result register.
// Throughput: one item per cycle unless the result stream stalls; the byte-wide
// CRC step and frame logic sit between the input register and the result register.
// Reset (rst, synchronous): frame state and counters clear, sync registers
// return to 238 and 200, both item registers empty.
// ----------------------------------------------------------------------------
module serial_frame_receiver_crc8_unit (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // rx_byte[7:0], clear_counts[8], zero[15:9]
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // data_byte[7:0], byte_index[14:8],
                                      // frame_status[16:15], frame_length[23:17],
                                      // good_frames[39:24], bad_frames[55:40]
  output logic        m_axis_tlast,   // frame_end
  output logic        m_axis_tuser    // byte_in_frame
);
  import sfr_pkg::*;

  in_item_t in_item;
  in_item_t held_item;
  logic     held_valid;
  logic     can_load;
  logic     advance;
  result_t  core_result;
  result_t  out_item;

  assign in_item.rx_byte      = s_axis_tdata[7:0];
  assign in_item.clear_counts = s_axis_tdata[8];

  // The held item moves on when the output register can take it.
  assign advance = held_valid && can_load;

  sfr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .advance    (can_load),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  sfr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (advance),
    .item      (held_item),
    .result    (core_result)
  );

  sfr_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load_valid (held_valid),
    .can_load   (can_load),
    .load_item  (core_result),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_item   (out_item)
  );

  // Pack the result item onto the stream.
  assign m_axis_tdata = {out_item.bad_frames, out_item.good_frames, out_item.frame_length,
                         out_item.frame_status, out_item.byte_index, out_item.data_byte};
  assign m_axis_tlast = out_item.frame_end;
  assign m_axis_tuser = out_item.byte_in_frame;

  // The input side stalls only behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a stalled result");

  // Both item registers are empty after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && !s_axis_tready == 1'b0))
    else $error("item registers not empty after reset");

  // A byte outside a frame has index zero.
  a_index_idle: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[14:8] == 7'd0))
    else $error("byte index set outside a frame");

  // Status is only reported at the end of a frame.
  a_status_end: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[16:15] == STATUS_GOOD))
    else $error("frame status set without frame end");

endmodule
